[sv/ccr_pkg.sv]
// shared types, constants and helpers for the circle canvas rasterizer
package ccr_pkg;

	localparam int MAX_DIM_DEF   = 256;
	localparam int FRAC_BITS_DEF = 8;
	localparam int QUEUE_DEPTH   = 2;

	localparam int COORD_W   = 19;
	localparam int RAD_W     = 18;
	localparam int RAD2_W    = 2 * RAD_W;
	localparam int DIM_W     = 9;
	localparam int CHAR_W    = 8;
	localparam int PIX_W     = 8;
	localparam int CFG_IDX_W = 2;

	typedef enum logic [1:0] {
		KIND_CLEAR = 2'd0,
		KIND_DRAW  = 2'd1,
		KIND_READ  = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_ZERO_RADIUS = 2'd1,
		ST_OUTSIDE     = 2'd2
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WIDTH  = 2'd0,
		CFG_HEIGHT = 2'd1,
		CFG_BG     = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_SWEEP,
		BK_DRAIN,
		BK_RD_ADDR,
		BK_RD_DATA,
		BK_FINISH
	} bk_state_t;

	// one classified item as it waits between front and back
	typedef struct packed {
		kind_t                     kind;
		status_t                   status;
		logic signed [COORD_W-1:0] cx;
		logic signed [COORD_W-1:0] cy;
		logic [RAD2_W-1:0]         r2;
		logic [RAD2_W-1:0]         ri2;
		logic                      has_inner;
		logic                      filled;
		logic [CHAR_W-1:0]         ch;
		logic [PIX_W-1:0]          col;
		logic [PIX_W-1:0]          row;
	} job_t;

	// zero acts as one, anything above the canvas limit acts as the limit
	function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v, input int max_dim);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (int'(v) > max_dim) begin
			r = DIM_W'(max_dim);
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

[sv/ccr_ram.sv]
// generic simple dual-port ram with registered read
module ccr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 65536,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[sv/ccr_front.sv]
// front end: takes items, squares the radii and classifies each item
module ccr_front #(
	parameter int FRAC_BITS = ccr_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_stall,
	input  logic [1:0]                        kind,
	input  logic signed [ccr_pkg::COORD_W-1:0] center_x,
	input  logic signed [ccr_pkg::COORD_W-1:0] center_y,
	input  logic [ccr_pkg::RAD_W-1:0]         radius,
	input  logic                              filled,
	input  logic [ccr_pkg::CHAR_W-1:0]        paint_char,
	input  logic [ccr_pkg::PIX_W-1:0]         pixel_col,
	input  logic [ccr_pkg::PIX_W-1:0]         pixel_row,
	input  logic [ccr_pkg::DIM_W-1:0]         eff_w,
	input  logic [ccr_pkg::DIM_W-1:0]         eff_h,
	input  logic [ccr_pkg::CHAR_W-1:0]        bg_char,
	input  logic                              q_full,
	output logic                              q_push,
	output ccr_pkg::job_t                     q_job
);
	import ccr_pkg::*;

	logic                      valid_s1;
	kind_t                     kind_s1;
	logic signed [COORD_W-1:0] cx_s1;
	logic signed [COORD_W-1:0] cy_s1;
	logic [RAD_W-1:0]          radius_s1;
	logic                      filled_s1;
	logic [CHAR_W-1:0]         char_s1;
	logic [PIX_W-1:0]          col_s1;
	logic [PIX_W-1:0]          row_s1;

	logic             accept;
	logic [RAD_W-1:0] unit;
	logic             has_inner;
	logic [RAD_W-1:0] r_inner;

	assign item_stall = valid_s1 && q_full;
	assign accept     = item_valid && !item_stall;
	assign q_push     = valid_s1 && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1   <= kind_t'(kind);
			cx_s1     <= center_x;
			cy_s1     <= center_y;
			radius_s1 <= radius;
			filled_s1 <= filled;
			char_s1   <= paint_char;
			col_s1    <= pixel_col;
			row_s1    <= pixel_row;
		end
	end

	always_comb begin
		unit      = RAD_W'(1) << FRAC_BITS;
		has_inner = radius_s1 >= unit;
		r_inner   = has_inner ? radius_s1 - unit : '0;

		q_job           = '0;
		q_job.kind      = kind_s1;
		q_job.cx        = cx_s1;
		q_job.cy        = cy_s1;
		q_job.r2        = radius_s1 * radius_s1;
		q_job.ri2       = r_inner * r_inner;
		q_job.has_inner = has_inner;
		q_job.filled    = filled_s1;
		q_job.col       = col_s1;
		q_job.row       = row_s1;
		// a clear paints with the background character
		q_job.ch        = (kind_s1 == KIND_CLEAR) ? bg_char : char_s1;
		q_job.status    = ST_OK;
		case (kind_s1)
			KIND_DRAW: begin
				if (radius_s1 == '0) begin
					q_job.status = ST_ZERO_RADIUS;
				end
			end
			KIND_READ: begin
				if ({1'b0, col_s1} >= eff_w || {1'b0, row_s1} >= eff_h) begin
					q_job.status = ST_OUTSIDE;
				end
			end
			default: begin
				q_job.status = ST_OK;
			end
		endcase
	end

endmodule

[sv/ccr_queue.sv]
// short fifo of classified words between front and back
module ccr_queue #(
	parameter int DEPTH = ccr_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  ccr_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output ccr_pkg::job_t pop_job,
	output logic          empty
);
	import ccr_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full    = count_q == CNT_W'(DEPTH);
	assign empty   = count_q == '0;
	assign pop_job = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

[sv/ccr_back.sv]
// back end: pixel sweep for clear and draw, pixel read, result register
module ccr_back #(
	parameter int MAX_DIM   = ccr_pkg::MAX_DIM_DEF,
	parameter int FRAC_BITS = ccr_pkg::FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       job_avail,
	input  ccr_pkg::job_t              job_in,
	output logic                       job_take,
	input  logic [ccr_pkg::DIM_W-1:0]  eff_w,
	input  logic [ccr_pkg::DIM_W-1:0]  eff_h,
	output logic                       result_valid,
	input  logic                       result_stall,
	output logic [1:0]                 status,
	output logic [ccr_pkg::CHAR_W-1:0] pixel_value
);
	import ccr_pkg::*;

	localparam int DEPTH  = MAX_DIM * MAX_DIM;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int POS_W  = DIM_W + FRAC_BITS;
	localparam int ABS_W  = ((POS_W > RAD_W) ? POS_W : RAD_W) + 1;
	localparam int DIFF_W = ABS_W + 1;
	localparam int SQ_W   = 2 * ABS_W;
	localparam int SUM_W  = SQ_W + 1;
	localparam int LIN_W  = DIM_W + PIX_W + 1;

	bk_state_t state_q, state_d;
	job_t      job_q;

	logic [DIM_W-1:0]  col_q;
	logic [DIM_W-1:0]  row_q;
	logic [ADDR_W-1:0] addr_q;

	logic              valid_s1;
	logic [ABS_W-1:0]  dx_s1;
	logic [ABS_W-1:0]  dy_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic              valid_s2;
	logic [SQ_W-1:0]   dx2_s2;
	logic [SQ_W-1:0]   dy2_s2;
	logic [ADDR_W-1:0] addr_s2;

	logic [CHAR_W-1:0] pix_q;
	logic              res_valid_q;
	status_t           res_status_q;
	logic [CHAR_W-1:0] res_pix_q;

	logic              issue;
	logic              last_px;
	logic              load_res;
	logic              pix_load;
	logic [DIFF_W-1:0] col_pos;
	logic [DIFF_W-1:0] row_pos;
	logic signed [DIFF_W-1:0] dif_x;
	logic signed [DIFF_W-1:0] dif_y;
	logic [ABS_W-1:0]  dx;
	logic [ABS_W-1:0]  dy;
	logic [SUM_W-1:0]  d2;
	logic              hit;
	logic              we;
	logic [LIN_W-1:0]  rd_lin;
	logic [ADDR_W-1:0] raddr;
	logic [CHAR_W-1:0] rdata;

	assign last_px = (col_q == eff_w - 1'b1) && (row_q == eff_h - 1'b1);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (job_avail) begin
					case (job_in.kind)
						KIND_CLEAR: state_d = BK_SWEEP;
						KIND_DRAW:  state_d = (job_in.status == ST_OK) ? BK_SWEEP : BK_FINISH;
						KIND_READ:  state_d = (job_in.status == ST_OK) ? BK_RD_ADDR : BK_FINISH;
						default:    state_d = BK_FINISH;
					endcase
				end
			end
			BK_SWEEP: begin
				if (last_px) begin
					state_d = BK_DRAIN;
				end
			end
			BK_DRAIN: begin
				if (!valid_s1 && !valid_s2) begin
					state_d = BK_FINISH;
				end
			end
			BK_RD_ADDR: state_d = BK_RD_DATA;
			BK_RD_DATA: state_d = BK_FINISH;
			BK_FINISH: begin
				if (!res_valid_q || !result_stall) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		job_take = 1'b0;
		issue    = 1'b0;
		load_res = 1'b0;
		pix_load = 1'b0;
		case (state_q)
			BK_IDLE:    job_take = job_avail;
			BK_SWEEP:   issue = 1'b1;
			BK_RD_DATA: pix_load = 1'b1;
			BK_FINISH:  load_res = !res_valid_q || !result_stall;
			default:    job_take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			valid_s1 <= issue;
			valid_s2 <= valid_s1;
			if (load_res) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// pixel counters walk the canvas row by row
	always_ff @(posedge clk) begin
		if (job_take) begin
			job_q  <= job_in;
			col_q  <= '0;
			row_q  <= '0;
			addr_q <= '0;
		end else if (issue) begin
			addr_q <= addr_q + 1'b1;
			if (col_q == eff_w - 1'b1) begin
				col_q <= '0;
				row_q <= row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
		if (job_take) begin
			pix_q <= '0;
		end else if (pix_load) begin
			pix_q <= rdata;
		end
		if (load_res) begin
			res_status_q <= job_q.status;
			res_pix_q    <= pix_q;
		end
	end

	// stage 1: offsets from the centre
	always_comb begin
		col_pos = DIFF_W'(col_q) << FRAC_BITS;
		row_pos = DIFF_W'(row_q) << FRAC_BITS;
		dif_x   = signed'(col_pos) - DIFF_W'(job_q.cx);
		dif_y   = signed'(row_pos) - DIFF_W'(job_q.cy);
		dx      = dif_x[DIFF_W-1] ? ABS_W'(-dif_x) : ABS_W'(dif_x);
		dy      = dif_y[DIFF_W-1] ? ABS_W'(-dif_y) : ABS_W'(dif_y);
	end

	always_ff @(posedge clk) begin
		dx_s1   <= dx;
		dy_s1   <= dy;
		addr_s1 <= addr_q;
		dx2_s2  <= dx_s1 * dx_s1;
		dy2_s2  <= dy_s1 * dy_s1;
		addr_s2 <= addr_s1;
	end

	// stage 2: squared distance against outer and inner radius
	always_comb begin
		d2  = dx2_s2 + dy2_s2;
		hit = (d2 <= SUM_W'(job_q.r2)) &&
			!(job_q.has_inner && d2 <= SUM_W'(job_q.ri2) && !job_q.filled);
		we  = valid_s2 && (job_q.kind == KIND_CLEAR || hit);
	end

	always_comb begin
		rd_lin = job_q.row * eff_w + job_q.col;
		raddr  = ADDR_W'(rd_lin);
	end

	ccr_ram #(
		.WIDTH (CHAR_W),
		.DEPTH (DEPTH),
		.ADDR_W(ADDR_W)
	) u_canvas (
		.clk  (clk),
		.we   (we),
		.waddr(addr_s2),
		.wdata(job_q.ch),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign result_valid = res_valid_q;
	assign status       = res_status_q;
	assign pixel_value  = res_pix_q;

endmodule

[sv/circle_canvas_rasterizer_top.sv]
// top level of the circle canvas rasterizer: config registers, front, queue, back
// throughput: the back handles one word at a time; a clear or draw visits one pixel per
//   cycle and writes each cleared or hit pixel through the canvas ram write port
// the front takes a new word each cycle until the two-entry queue and its input stage fill
// reset: control and queue clear, config returns to 256 x 256 with a space background;
//   the canvas has no clearing pass and holds garbage until the first clear
module circle_canvas_rasterizer_top #(
	parameter int MAX_DIM   = ccr_pkg::MAX_DIM_DEF,
	parameter int FRAC_BITS = ccr_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ccr_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ccr_pkg::DIM_W-1:0]           cfg_data,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  logic [1:0]                          kind,
	input  logic signed [ccr_pkg::COORD_W-1:0]  center_x,
	input  logic signed [ccr_pkg::COORD_W-1:0]  center_y,
	input  logic [ccr_pkg::RAD_W-1:0]           radius,
	input  logic                                filled,
	input  logic [ccr_pkg::CHAR_W-1:0]          paint_char,
	input  logic [ccr_pkg::PIX_W-1:0]           pixel_col,
	input  logic [ccr_pkg::PIX_W-1:0]           pixel_row,
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic [1:0]                          status,
	output logic [ccr_pkg::CHAR_W-1:0]          pixel_value
);
	import ccr_pkg::*;

	logic [DIM_W-1:0]  width_q;
	logic [DIM_W-1:0]  height_q;
	logic [CHAR_W-1:0] bg_q;
	logic [DIM_W-1:0]  eff_w;
	logic [DIM_W-1:0]  eff_h;

	logic q_push;
	logic q_full;
	logic q_pop;
	logic q_empty;
	job_t push_job;
	job_t pop_job;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_W'(256);
			height_q <= DIM_W'(256);
			bg_q     <= CHAR_W'(32);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_WIDTH:  width_q <= cfg_data;
				CFG_HEIGHT: height_q <= cfg_data;
				CFG_BG:     bg_q <= cfg_data[CHAR_W-1:0];
				default:    bg_q <= bg_q;
			endcase
		end
	end

	assign eff_w = eff_dim(width_q, MAX_DIM);
	assign eff_h = eff_dim(height_q, MAX_DIM);

	ccr_front #(
		.FRAC_BITS(FRAC_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.kind      (kind),
		.center_x  (center_x),
		.center_y  (center_y),
		.radius    (radius),
		.filled    (filled),
		.paint_char(paint_char),
		.pixel_col (pixel_col),
		.pixel_row (pixel_row),
		.eff_w     (eff_w),
		.eff_h     (eff_h),
		.bg_char   (bg_q),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_job     (push_job)
	);

	ccr_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_job(push_job),
		.full    (q_full),
		.pop     (q_pop),
		.pop_job (pop_job),
		.empty   (q_empty)
	);

	ccr_back #(
		.MAX_DIM  (MAX_DIM),
		.FRAC_BITS(FRAC_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.job_avail   (!q_empty),
		.job_in      (pop_job),
		.job_take    (q_pop),
		.eff_w       (eff_w),
		.eff_h       (eff_h),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.status      (status),
		.pixel_value (pixel_value)
	);

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("queue written while full");

	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("queue read while empty");

	a_error_has_no_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && status != ST_OK) |-> pixel_value == '0)
		else $error("error result carries a pixel value");

endmodule
